// ===== rtl/nls_pkg.sv =====
// nls_pkg: shared types, codes and helpers for the numeric literal scanner.
// Used by nls_core and numeric_literal_scanner; depends on nothing else.
`default_nettype none

package nls_pkg;

	// default sizes, handed to the top level as parameter defaults
	localparam int MAX_CHARS_DEF   = 40;
	localparam int VALUE_WIDTH_DEF = 64;

	// character codes
	localparam logic [6:0] CH_DOT   = 7'h2E;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_0     = 7'h30;
	localparam logic [6:0] CH_9     = 7'h39;
	localparam logic [6:0] CH_UA    = 7'h41;
	localparam logic [6:0] CH_UZ    = 7'h5A;
	localparam logic [6:0] CH_LA    = 7'h61;
	localparam logic [6:0] CH_LB    = 7'h62;
	localparam logic [6:0] CH_LE    = 7'h65;
	localparam logic [6:0] CH_LF    = 7'h66;
	localparam logic [6:0] CH_LX    = 7'h78;
	localparam logic [6:0] CH_LZ    = 7'h7A;

	// offset from a folded letter to its digit value ('a' - 10)
	localparam logic [7:0] LETTER_BIAS = 8'd87;
	localparam logic [7:0] DIGIT_BIAS  = 8'd48;

	// first_digit marker for a non-digit first character
	localparam logic [3:0] NO_DIGIT = 4'd15;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_INT   = 2'd1,
		PH_FLOAT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RC_DEC = 2'd0,
		RC_OCT = 2'd1,
		RC_HEX = 2'd2,
		RC_BIN = 2'd3
	} radix_code_t;

	typedef enum logic [1:0] {
		KIND_INT   = 2'd0,
		KIND_FWD   = 2'd1,
		KIND_BWD   = 2'd2,
		KIND_FLOAT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_DIGIT     = 2'd1,
		ERR_TOO_LONG  = 2'd2,
		ERR_BAD_LABEL = 2'd3
	} err_t;

	localparam logic [4:0] RADIX_2  = 5'd2;
	localparam logic [4:0] RADIX_8  = 5'd8;
	localparam logic [4:0] RADIX_10 = 5'd10;
	localparam logic [4:0] RADIX_16 = 5'd16;

	// input word: one source character
	typedef struct packed {
		logic [6:0] ch;
		logic       begin_req;
	} chr_word_t;

	// result word: one scanned literal
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] value;
		logic [4:0]  radix;
		logic [3:0]  label_digit;
		logic [5:0]  text_length;
		logic [1:0]  error;
	} lit_word_t;

	// scanner state other than the accumulator
	typedef struct packed {
		phase_t      phase;
		radix_code_t radix_code;
		logic [5:0]  char_count;
		logic [3:0]  first_digit;
		logic [6:0]  second_char;
		logic [6:0]  last_char;
		logic        digit_error;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase:       PH_IDLE,
		radix_code:  RC_DEC,
		char_count:  6'd0,
		first_digit: 4'd0,
		second_char: 7'd0,
		last_char:   7'd0,
		digit_error: 1'b0
	};

	function automatic logic [4:0] radix_of(radix_code_t rc);
		logic [4:0] r;
		unique case (rc)
			RC_DEC:  r = RADIX_10;
			RC_OCT:  r = RADIX_8;
			RC_HEX:  r = RADIX_16;
			RC_BIN:  r = RADIX_2;
			default: r = RADIX_10;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] fold(logic [6:0] c);
		logic [6:0] f;
		f = c;
		if (c >= CH_UA && c <= CH_UZ)
			f = c + (CH_LA - CH_UA);
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nls_core.sv =====
// nls_core: one scanning step, next state and result from the current state
// and one character. Purely combinational; depends on nls_pkg.
`default_nettype none

module nls_core
	import nls_pkg::*;
#(
	parameter int MAX_CHARS   = MAX_CHARS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire chr_word_t              word,
	input  wire scan_state_t            st,
	input  wire [VALUE_WIDTH-1:0]       acc,
	output scan_state_t                 st_nxt,
	output logic [VALUE_WIDTH-1:0]      acc_nxt,
	output logic                        res_valid,
	output lit_word_t                   res
);

	localparam logic [5:0] MAX_CNT = 6'(MAX_CHARS);

	logic [6:0]             c_raw;
	logic [6:0]             c_f;
	logic                   is_dig;
	logic                   is_alnum;
	logic                   is_float_ch;
	logic                   at_max;
	radix_code_t            add_rc;
	logic [7:0]             dval;
	logic                   d_err;
	logic [VALUE_WIDTH-1:0] acc_base;
	logic [VALUE_WIDTH-1:0] acc_mul;
	logic [VALUE_WIDTH-1:0] acc_add;
	logic [63:0]            acc_ext;

	// character classes
	assign c_raw       = word.ch;
	assign c_f         = fold(c_raw);
	assign is_dig      = (c_f >= CH_0) && (c_f <= CH_9);
	assign is_alnum    = is_dig || ((c_f >= CH_LA) && (c_f <= CH_LZ));
	assign is_float_ch = is_dig || (c_f == CH_DOT) || (c_f == CH_LE) ||
	                     (c_f == CH_PLUS) || (c_f == CH_MINUS);
	assign at_max      = (st.char_count >= MAX_CNT);

	// digit value (signed, wraps like the accumulator) and range check
	assign add_rc = word.begin_req ? ((c_f == CH_0) ? RC_OCT : RC_DEC) : st.radix_code;
	assign dval   = (c_f > CH_9) ? ({1'b0, c_f} - LETTER_BIAS) : ({1'b0, c_f} - DIGIT_BIAS);
	assign d_err  = dval[7] || (dval[6:0] >= {2'b00, radix_of(add_rc)});

	// shift-add accumulate
	assign acc_base = word.begin_req ? '0 : acc;
	always_comb begin
		unique case (add_rc)
			RC_DEC:  acc_mul = (acc_base << 3) + (acc_base << 1);
			RC_OCT:  acc_mul = acc_base << 3;
			RC_HEX:  acc_mul = acc_base << 4;
			RC_BIN:  acc_mul = acc_base << 1;
			default: acc_mul = acc_base;
		endcase
	end
	assign acc_add = acc_mul + {{(VALUE_WIDTH-8){dval[7]}}, dval};

	always_comb begin
		acc_ext = '0;
		acc_ext[VALUE_WIDTH-1:0] = acc;
	end

	// next state
	always_comb begin
		st_nxt  = st;
		acc_nxt = acc;
		if (word.begin_req) begin
			st_nxt = SCAN_RESET;
			st_nxt.char_count = 6'd1;
			if (c_raw == CH_DOT) begin
				st_nxt.phase = PH_FLOAT;
				acc_nxt      = '0;
			end else begin
				st_nxt.phase       = PH_INT;
				st_nxt.radix_code  = add_rc;
				st_nxt.first_digit = is_dig ? 4'(c_f - CH_0) : NO_DIGIT;
				st_nxt.digit_error = d_err;
				st_nxt.last_char   = c_f;
				acc_nxt            = acc_add;
			end
		end else begin
			unique case (st.phase)
				PH_INT: begin
					if (c_raw == CH_DOT) begin
						if (at_max) begin
							st_nxt.phase = PH_IDLE;
						end else begin
							st_nxt.phase      = PH_FLOAT;
							st_nxt.char_count = st.char_count + 6'd1;
						end
					end else if (!is_alnum || at_max) begin
						st_nxt.phase = PH_IDLE;
					end else begin
						if (st.char_count == 6'd1)
							st_nxt.second_char = c_f;
						if (st.char_count == 6'd1 && st.radix_code == RC_OCT && c_f == CH_LX) begin
							st_nxt.radix_code = RC_HEX;
						end else if (st.char_count == 6'd1 && st.radix_code == RC_OCT &&
						             c_f == CH_LB) begin
							st_nxt.radix_code = RC_BIN;
						end else begin
							acc_nxt = acc_add;
							if (d_err)
								st_nxt.digit_error = 1'b1;
						end
						st_nxt.last_char  = c_f;
						st_nxt.char_count = st.char_count + 6'd1;
					end
				end
				PH_FLOAT: begin
					if (!is_float_ch || at_max)
						st_nxt.phase = PH_IDLE;
					else
						st_nxt.char_count = st.char_count + 6'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// result word
	always_comb begin
		res_valid       = 1'b0;
		res.kind        = KIND_INT;
		res.value       = '0;
		res.radix       = radix_of(st.radix_code);
		res.label_digit = 4'd0;
		res.text_length = st.char_count;
		res.error       = ERR_NONE;
		if (!word.begin_req) begin
			unique case (st.phase)
				PH_INT: begin
					if ((c_raw == CH_DOT && at_max) || (is_alnum && at_max)) begin
						// too long
						res_valid       = 1'b1;
						res.text_length = MAX_CNT;
						res.error       = ERR_TOO_LONG;
						if (c_raw == CH_DOT)
							res.radix = RADIX_10;
					end else if (c_raw != CH_DOT && !is_alnum) begin
						res_valid = 1'b1;
						if (st.radix_code != RC_HEX &&
						    (st.last_char == CH_LF || st.last_char == CH_LB)) begin
							if (st.first_digit < 4'd10 && st.char_count >= 6'd2 &&
							    st.second_char == CH_LF) begin
								res.kind        = KIND_FWD;
								res.label_digit = st.first_digit;
							end else if (st.first_digit < 4'd10 && st.char_count == 6'd2) begin
								res.kind        = KIND_BWD;
								res.label_digit = st.first_digit;
							end else begin
								res.kind  = KIND_FWD;
								res.error = ERR_BAD_LABEL;
							end
						end else begin
							res.value = acc_ext;
							res.error = st.digit_error ? ERR_DIGIT : ERR_NONE;
						end
					end
				end
				PH_FLOAT: begin
					res.radix = RADIX_10;
					if (!is_float_ch) begin
						res_valid = 1'b1;
						res.kind  = KIND_FLOAT;
					end else if (at_max) begin
						res_valid       = 1'b1;
						res.text_length = MAX_CNT;
						res.error       = ERR_TOO_LONG;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/numeric_literal_scanner.sv =====
// numeric_literal_scanner: top level, input register, scan state and result register.
// Depends on nls_pkg and nls_core.
`default_nettype none

// Scans assembler numeric literals one character per word and hands out one
// result word when the character that ends a literal arrives (that character
// is not consumed). A character word is taken every cycle while the input does not
// stall: it lands in an input register, is scanned against the held state by a
// single shift-add step, and the result lands in an output register. The input
// stalls only while a waiting character word cannot move on because the output
// register is full and stalled.
module numeric_literal_scanner
	import nls_pkg::*;
#(
	parameter int MAX_CHARS   = MAX_CHARS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              chr_valid,
	output logic             chr_stall,
	input  wire chr_word_t   chr_data,
	output logic             lit_valid,
	input  wire              lit_stall,
	output lit_word_t        lit_data
);

	logic                   valid_s1;
	chr_word_t              word_s1;
	scan_state_t            st_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	scan_state_t            st_nxt;
	logic [VALUE_WIDTH-1:0] acc_nxt;
	logic                   res_valid;
	lit_word_t              res;
	logic                   out_valid_q;
	lit_word_t              out_q;
	logic                   out_free;
	logic                   step;

	// handshake
	assign out_free  = !out_valid_q || !lit_stall;
	assign step      = valid_s1 && out_free;
	assign chr_stall = valid_s1 && !out_free;
	assign lit_valid = out_valid_q;
	assign lit_data  = out_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!chr_stall) begin
			valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_valid && !chr_stall)
			word_s1 <= chr_data;
	end

	nls_core #(
		.MAX_CHARS   (MAX_CHARS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_core (
		.word      (word_s1),
		.st        (st_q),
		.acc       (acc_q),
		.st_nxt    (st_nxt),
		.acc_nxt   (acc_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= SCAN_RESET;
			acc_q <= '0;
		end else if (step) begin
			st_q  <= st_nxt;
			acc_q <= acc_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!lit_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid)
			out_q <= res;
	end

endmodule

`default_nettype wire

// ===== sim/numeric_literal_scanner_tb.sv =====
// numeric_literal_scanner_tb: self-checking bench for the numeric literal scanner.
// Drives character words, predicts each literal result and checks it field by field.
// Depends on nls_pkg and numeric_literal_scanner.
`default_nettype none

module numeric_literal_scanner_tb
	import nls_pkg::*;
();

	localparam int TEXT_MAX      = MAX_CHARS_DEF;
	localparam int IDLE_PERCENT  = 19;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_WORDS  = 1300;
	localparam int CALM_WORDS    = 450;

	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_COMMA = 7'h2C;
	localparam logic [6:0] CH_NL    = 7'h0A;
	localparam logic [6:0] CH_SEMI  = 7'h3B;
	localparam logic [6:0] CH_DEL   = 7'h7F;
	localparam logic [6:0] CH_UX    = 7'h58;
	localparam logic [6:0] CH_UB    = 7'h42;
	localparam logic [6:0] CH_UF    = 7'h46;
	localparam logic [6:0] CH_UE    = 7'h45;

	logic      clk;
	logic      arst_n;
	logic      chr_valid;
	logic      chr_stall;
	chr_word_t chr_data;
	logic      lit_valid;
	logic      lit_stall;
	lit_word_t lit_data;

	// no idling on either side while set
	bit        calm;
	int        mismatches;
	int        results_seen;
	int        sent_words;
	int        quiet_cycles;
	lit_word_t pending_lits[$];
	logic [6:0] lit_text[$];

	// scanner state as predicted
	phase_t      sc_phase;
	radix_code_t sc_rc;
	logic [63:0] sc_acc;
	logic [5:0]  sc_count;
	logic [3:0]  sc_first;
	logic [6:0]  sc_second;
	logic [6:0]  sc_last;
	logic        sc_derr;

	numeric_literal_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_data  (chr_data),
		.lit_valid (lit_valid),
		.lit_stall (lit_stall),
		.lit_data  (lit_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// character classes
	function automatic bit is_dec(logic [6:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_alnum(logic [6:0] c);
		return is_dec(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic logic [6:0] lower_case(logic [6:0] c);
		return (c >= CH_UA && c <= CH_UZ) ? c + (CH_LA - CH_UA) : c;
	endfunction

	function automatic logic [4:0] base_of(radix_code_t rc);
		case (rc)
			RC_OCT:  return RADIX_8;
			RC_HEX:  return RADIX_16;
			RC_BIN:  return RADIX_2;
			default: return RADIX_10;
		endcase
	endfunction

	function automatic lit_word_t lit_result(kind_t k, logic [63:0] v, logic [4:0] r,
			logic [3:0] l, logic [5:0] n, err_t e);
		lit_word_t w;
		w.kind        = k;
		w.value       = v;
		w.radix       = r;
		w.label_digit = l;
		w.text_length = n;
		w.error       = e;
		return w;
	endfunction

	task automatic clear_scan();
		sc_phase  = PH_IDLE;
		sc_rc     = RC_DEC;
		sc_acc    = '0;
		sc_count  = '0;
		sc_first  = '0;
		sc_second = '0;
		sc_last   = '0;
		sc_derr   = 1'b0;
	endtask

	// shift-add one digit; anything at or above the radix flags but still adds
	task automatic accumulate(logic [6:0] c);
		logic [63:0] r;
		logic [63:0] d;
		r = 64'(base_of(sc_rc));
		d = (c > CH_9) ? 64'(c) - 64'(LETTER_BIAS) : 64'(c) - 64'(DIGIT_BIAS);
		if (d >= r)
			sc_derr = 1'b1;
		sc_acc = sc_acc * r + d;
	endtask

	// integer end: label forms outside hex, else the accumulated value
	function automatic lit_word_t integer_end();
		logic [4:0] r;
		r = base_of(sc_rc);
		if (sc_rc != RC_HEX && (sc_last == CH_LF || sc_last == CH_LB)) begin
			if (sc_first < 4'd10 && sc_count >= 6'd2) begin
				if (sc_second == CH_LF)
					return lit_result(KIND_FWD, '0, r, sc_first, sc_count, ERR_NONE);
				if (sc_count == 6'd2)
					return lit_result(KIND_BWD, '0, r, sc_first, sc_count, ERR_NONE);
			end
			return lit_result(KIND_FWD, '0, r, 4'd0, sc_count, ERR_BAD_LABEL);
		end
		return lit_result(KIND_INT, sc_acc, r, 4'd0, sc_count, sc_derr ? ERR_DIGIT : ERR_NONE);
	endfunction

	// advance the predicted scanner by one character word
	task automatic scan_word(input chr_word_t w, output bit got, output lit_word_t res,
			output bit ignored);
		logic [6:0] c;
		c       = w.ch;
		got     = 1'b0;
		ignored = 1'b0;
		res     = '0;
		if (w.begin_req) begin
			clear_scan();
			if (c == CH_DOT) begin
				sc_phase = PH_FLOAT;
				sc_count = 6'd1;
			end else begin
				c        = lower_case(c);
				sc_phase = PH_INT;
				sc_rc    = (c == CH_0) ? RC_OCT : RC_DEC;
				sc_first = is_dec(c) ? 4'(c - CH_0) : NO_DIGIT;
				accumulate(c);
				sc_last  = c;
				sc_count = 6'd1;
			end
		end else begin
			case (sc_phase)
				PH_INT: begin
					if (c == CH_DOT) begin
						if (sc_count >= TEXT_MAX) begin
							got = 1'b1;
							res = lit_result(KIND_INT, '0, RADIX_10, 4'd0, 6'(TEXT_MAX),
								ERR_TOO_LONG);
						end else begin
							sc_count = sc_count + 6'd1;
							sc_phase = PH_FLOAT;
						end
					end else if (!is_alnum(c)) begin
						got = 1'b1;
						res = integer_end();
					end else if (sc_count >= TEXT_MAX) begin
						got = 1'b1;
						res = lit_result(KIND_INT, '0, base_of(sc_rc), 4'd0, 6'(TEXT_MAX),
							ERR_TOO_LONG);
					end else begin
						c = lower_case(c);
						if (sc_count == 6'd1) begin
							// second character may pick the radix instead of adding
							sc_second = c;
							if (sc_rc == RC_OCT && c == CH_LX)
								sc_rc = RC_HEX;
							else if (sc_rc == RC_OCT && c == CH_LB)
								sc_rc = RC_BIN;
							else
								accumulate(c);
						end else begin
							accumulate(c);
						end
						sc_last  = c;
						sc_count = sc_count + 6'd1;
					end
				end
				PH_FLOAT: begin
					c = lower_case(c);
					if (is_dec(c) || c == CH_DOT || c == CH_LE ||
							c == CH_PLUS || c == CH_MINUS) begin
						if (sc_count >= TEXT_MAX) begin
							got = 1'b1;
							res = lit_result(KIND_INT, '0, RADIX_10, 4'd0, 6'(TEXT_MAX),
								ERR_TOO_LONG);
						end else begin
							sc_count = sc_count + 6'd1;
						end
					end else begin
						got = 1'b1;
						res = lit_result(KIND_FLOAT, '0, RADIX_10, 4'd0, sc_count, ERR_NONE);
					end
				end
				default: ignored = 1'b1;
			endcase
		end
		if (got)
			sc_phase = PH_IDLE;
	endtask

	// send one character word, idling at random first
	task automatic send_chr(input logic [6:0] c, input logic b);
		chr_word_t w;
		bit        got;
		bit        ignored;
		lit_word_t res;
		w.ch        = c;
		w.begin_req = b;
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			chr_valid <= 1'b0;
			@(posedge clk);
		end
		chr_valid <= 1'b1;
		chr_data  <= w;
		@(posedge clk);
		while (chr_stall)
			@(posedge clk);
		scan_word(w, got, res, ignored);
		if (got)
			pending_lits.push_back(res);
		if (!ignored)
			sent_words++;
	endtask

	// send the gathered literal text, begin on its first word, then the ender if any
	task automatic send_lit(input logic [6:0] ender, input bit ended);
		foreach (lit_text[i])
			send_chr(lit_text[i], i == 0);
		if (ended)
			send_chr(ender, 1'b0);
		lit_text.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			lit_text.push_back(7'(s[i]));
	endtask

	task automatic add_run(input logic [6:0] c, input int n);
		repeat (n)
			lit_text.push_back(c);
	endtask

	task automatic lit(input string s, input logic [6:0] ender);
		add_text(s);
		send_lit(ender, 1'b1);
	endtask

	// hold the sender until every expected literal is back, then let the pipe settle
	task automatic drain();
		chr_valid <= 1'b0;
		while (pending_lits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// random character pickers
	function automatic logic [6:0] rand_digit(int top);
		return CH_0 + 7'($urandom_range(top));
	endfunction

	function automatic logic [6:0] rand_hex();
		int r;
		r = $urandom_range(21);
		if (r < 10)
			return CH_0 + 7'(r);
		if (r < 16)
			return CH_LA + 7'(r - 10);
		return CH_UA + 7'(r - 16);
	endfunction

	function automatic logic [6:0] rand_alnum();
		int r;
		r = $urandom_range(61);
		if (r < 10)
			return CH_0 + 7'(r);
		if (r < 36)
			return CH_LA + 7'(r - 10);
		return CH_UA + 7'(r - 36);
	endfunction

	// a character that ends both integer and float text
	function automatic logic [6:0] rand_ender();
		logic [6:0] c;
		c = 7'($urandom_range(127));
		while (is_alnum(c) || c == CH_DOT || c == CH_PLUS || c == CH_MINUS)
			c = 7'($urandom_range(127));
		return c;
	endfunction

	function automatic logic [6:0] pick_case(logic [6:0] lower, logic [6:0] upper);
		return $urandom_range(1) ? lower : upper;
	endfunction

	// build one well-formed literal (or a near miss) into lit_text
	task automatic make_random_literal();
		int form;
		int n;
		form = $urandom_range(99);
		if (form < 18) begin
			lit_text.push_back(CH_0 + 7'($urandom_range(1, 9)));
			n = $urandom_range(19);
			repeat (n) lit_text.push_back(rand_digit(9));
		end else if (form < 32) begin
			lit_text.push_back(CH_0);
			lit_text.push_back(pick_case(CH_LX, CH_UX));
			n = $urandom_range(18);
			repeat (n) lit_text.push_back(rand_hex());
		end else if (form < 42) begin
			lit_text.push_back(CH_0);
			lit_text.push_back(pick_case(CH_LB, CH_UB));
			n = $urandom_range(36);
			repeat (n)
				lit_text.push_back($urandom_range(19) == 0 ? rand_digit(9) : rand_digit(1));
		end else if (form < 50) begin
			lit_text.push_back(CH_0);
			n = $urandom_range(22);
			repeat (n)
				lit_text.push_back($urandom_range(19) == 0 ? rand_digit(9) : rand_digit(7));
		end else if (form < 60) begin
			lit_text.push_back(rand_digit(9));
			lit_text.push_back(pick_case(CH_LF, CH_UF));
			if ($urandom_range(3) == 0) begin
				n = $urandom_range(1, 3);
				repeat (n) lit_text.push_back(rand_alnum());
			end
		end else if (form < 68) begin
			lit_text.push_back(rand_digit(9));
			lit_text.push_back(pick_case(CH_LB, CH_UB));
		end else if (form < 74) begin
			// label endings that do not make a valid label
			lit_text.push_back($urandom_range(3) == 0 ? rand_alnum() : rand_digit(9));
			n = $urandom_range(1, 4);
			repeat (n) lit_text.push_back(rand_digit(9));
			lit_text.push_back($urandom_range(1) ? pick_case(CH_LF, CH_UF) :
				pick_case(CH_LB, CH_UB));
		end else if (form < 86) begin
			n = $urandom_range(4);
			repeat (n) lit_text.push_back(rand_digit(9));
			lit_text.push_back(CH_DOT);
			n = $urandom_range(6);
			repeat (n) lit_text.push_back(rand_digit(9));
			if ($urandom_range(1)) begin
				lit_text.push_back(pick_case(CH_LE, CH_UE));
				if ($urandom_range(1))
					lit_text.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
				n = $urandom_range(1, 3);
				repeat (n) lit_text.push_back(rand_digit(9));
			end
		end else if (form < 91) begin
			// around the length limit
			n = $urandom_range(TEXT_MAX - 2, TEXT_MAX + 4);
			lit_text.push_back(CH_0 + 7'($urandom_range(1, 9)));
			repeat (n - 1) lit_text.push_back(rand_digit(9));
			if ($urandom_range(2) == 0)
				lit_text[$urandom_range(2, n - 1)] = CH_DOT;
		end else begin
			lit_text.push_back(rand_alnum());
			n = $urandom_range(1, 10);
			repeat (n) lit_text.push_back(rand_alnum());
		end
	endtask

	// random mix of literals, restarts and noise until enough words are scanned
	task automatic random_run(input int words);
		int base;
		int pick;
		base = sent_words;
		while (sent_words - base < words) begin
			if ($urandom_range(99) < 80) begin
				make_random_literal();
				pick = $urandom_range(99);
				if (pick < 72)
					send_lit(rand_ender(), 1'b1);
				else if (pick < 87)
					send_lit(CH_SPACE, 1'b0);
				else
					send_lit(7'($urandom_range(127)), 1'b1);
			end else begin
				repeat ($urandom_range(1, 4))
					send_chr(7'($urandom_range(127)), $urandom_range(3) == 0);
			end
		end
		drain();
	endtask

	// radix prefixes and upper-case folding
	task automatic test_radix_prefixes();
		lit("0", CH_SPACE);
		lit("123", CH_COMMA);
		lit("0x1F", CH_SPACE);
		lit("0XaB", CH_NL);
		lit("0b101", CH_SPACE);
		lit("017", CH_SEMI);
		drain();
	endtask

	// largest value, wrap past 2^64, prefix with no digits
	task automatic test_value_extremes();
		lit("0xffffffffffffffff", CH_SPACE);
		lit("18446744073709551616", CH_SPACE);
		lit("0x", CH_SPACE);
		drain();
	endtask

	// digits at or above the radix, non-digit first character
	task automatic test_digit_errors();
		lit("08", CH_SPACE);
		lit("0b102", CH_SPACE);
		lit("12z", CH_SPACE);
		lit("q1", CH_SPACE);
		drain();
	endtask

	// forward, backward and bad local labels
	task automatic test_labels();
		lit("1f", CH_SPACE);
		lit("2B", CH_SPACE);
		lit("0b", CH_SPACE);
		lit("9F", CH_COMMA);
		lit("3fb", CH_SPACE);
		lit("12f", CH_SPACE);
		lit("45b", CH_SPACE);
		drain();
	endtask

	// float text, including a leading dot
	task automatic test_float_text();
		lit(".5", CH_SPACE);
		lit("1.5e+3", CH_SPACE);
		lit("2.-", CH_LX);
		lit("1.2.3", CH_COMMA);
		drain();
	endtask

	// idle characters, and a new literal starting over an unfinished one
	task automatic test_restart_and_idle();
		send_chr(CH_LX, 1'b0);
		send_chr(CH_SPACE, 1'b0);
		add_text("12");
		send_lit(CH_SPACE, 1'b0);
		add_text("3.4");
		send_lit(CH_SPACE, 1'b0);
		lit("56", CH_SPACE);
		send_chr(CH_DEL, 1'b0);
		drain();
	endtask

	// exactly the limit, one past it as digit, dot and float text
	task automatic test_too_long();
		add_run(CH_9, TEXT_MAX);
		send_lit(CH_SPACE, 1'b1);
		add_run(CH_9, TEXT_MAX + 1);
		send_lit(CH_SPACE, 1'b1);
		add_text("0x");
		add_run(CH_LF, TEXT_MAX - 2);
		send_lit(CH_DOT, 1'b1);
		add_text("0x");
		add_run(CH_UF, TEXT_MAX - 1);
		send_lit(CH_SPACE, 1'b1);
		add_text("1.");
		add_run(CH_0, TEXT_MAX - 1);
		send_lit(CH_SPACE, 1'b1);
		drain();
	endtask

	// random traffic, first with no idling on either side, then with idling
	task automatic test_random_traffic();
		calm = 1'b1;
		random_run(CALM_WORDS);
		calm = 1'b0;
		random_run(RANDOM_WORDS - CALM_WORDS);
	endtask

	// receiver stall, random except during calm stretches
	always @(posedge clk)
		lit_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

	// compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		lit_word_t want;
		if (arst_n && lit_valid && !lit_stall) begin
			results_seen++;
			if (pending_lits.size() == 0) begin
				if (mismatches < 10)
					$display({"literal %0d: none expected, got kind %0d value %h ",
						"radix %0d label %0d len %0d err %0d"},
						results_seen, lit_data.kind, lit_data.value, lit_data.radix,
						lit_data.label_digit, lit_data.text_length, lit_data.error);
				mismatches++;
			end else begin
				want = pending_lits.pop_front();
				if (lit_data.kind !== want.kind || lit_data.value !== want.value ||
						lit_data.radix !== want.radix ||
						lit_data.label_digit !== want.label_digit ||
						lit_data.text_length !== want.text_length ||
						lit_data.error !== want.error) begin
					if (mismatches < 10) begin
						$display({"literal %0d: expected kind %0d value %h radix %0d ",
							"label %0d len %0d err %0d"},
							results_seen, want.kind, want.value, want.radix, want.label_digit,
							want.text_length, want.error);
						$display({"literal %0d:   actual kind %0d value %h radix %0d ",
							"label %0d len %0d err %0d"},
							results_seen, lit_data.kind, lit_data.value, lit_data.radix,
							lit_data.label_digit, lit_data.text_length, lit_data.error);
					end
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (chr_valid && !chr_stall) || (lit_valid && !lit_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		chr_valid    = 1'b0;
		chr_data     = '0;
		lit_stall    = 1'b0;
		calm         = 1'b0;
		mismatches   = 0;
		results_seen = 0;
		sent_words   = 0;
		quiet_cycles = 0;
		clear_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_radix_prefixes();
		test_value_extremes();
		test_digit_errors();
		test_labels();
		test_float_text();
		test_restart_and_idle();
		test_too_long();
		test_random_traffic();

		if (mismatches == 0 && pending_lits.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/nls_pkg.sv
rtl/nls_core.sv
rtl/numeric_literal_scanner.sv
sim/numeric_literal_scanner_tb.sv
